FILE: rtl/plss_pkg.sv
// Package for the pen line stroke synthesizer: widths, result kind codes and
// fixed arithmetic constants. No dependencies; imported by the top level and
// by its port checker.
package plss_pkg;

  localparam int COORD_BITS    = 10;
  localparam int DWELL_SAMPLES = 60;

  localparam int RATE_W  = 8;
  localparam int KIND_W  = 3;
  localparam int PRESS_W = 3;
  localparam int PC_W    = 10;
  localparam int ET_W    = 16;
  localparam int GAP_W   = 6;
  localparam int POS_W   = COORD_BITS + 3;
  localparam int STEP_W  = COORD_BITS - 1;
  localparam int IDX_W   = COORD_BITS;
  localparam int PROD_W  = COORD_BITS + IDX_W;
  localparam int CNT_W   = (COORD_BITS + 1 > PC_W + 1) ? COORD_BITS + 1 : PC_W + 1;
  localparam int DIV_W   = (PROD_W > CNT_W + 6) ? PROD_W : CNT_W + 6;
  localparam int DVS_W   = (STEP_W > RATE_W) ? STEP_W : RATE_W;
  localparam int DCNT_W  = $clog2(DIV_W + 1);
  localparam int ETF_W   = DIV_W + 2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_HEADER = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PEN    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_UP     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_GAP    = 3'd3;
  localparam logic [KIND_W-1:0] KIND_DOWN   = 3'd4;
  localparam logic [KIND_W-1:0] KIND_IDLE   = 3'd5;

  localparam logic [PRESS_W-1:0] PEN_PRESSURE = 3'd4;

  localparam logic [RATE_W-1:0] TICK_RATE_RESET = 8'd60;
  localparam int                STEPS_DEFAULT   = 10;
  localparam int                DTAP_LIMIT      = 4;
  localparam int                ET_BASE         = 5;
  localparam int                ET_SELECT_NUM   = 3600;
  localparam int                ET_MAX          = 65535;
  localparam int                PC_MAX          = 1023;

  // floor(rate * 9 / 60) == (rate * GAP_RECIP) >> GAP_SHIFT for every 8-bit rate
  localparam int GAP_RECIP   = 9831;
  localparam int GAP_SHIFT   = 16;
  localparam int GAP_PROD_W  = RATE_W + 14;

endpackage

FILE: rtl/pen_line_stroke_synthesizer.sv
// Top level of the pen line stroke synthesizer: stroke sequencer, header
// arithmetic and a two-lane bit-serial divider. Depends on plss_pkg.
//
// Usage
//   Write the tick rate (samples per second) on the cfg channel while idle;
//   cfg_ready_o is always high. A transaction on the input channel with
//   action_i = 0 starts a line stroke from the two end points and returns one
//   header (point count, end time). Each later transaction with action_i = 1
//   returns the next sample: dwell samples for a selection, line samples,
//   and for a double tap a pen up, null gap samples, a pen down and the line
//   once more. A pull with no stroke running returns an idle result.
// Divider and throughput
//   Headers and mid-line samples go through the divider, which makes one
//   quotient bit per cycle in restoring form; x and y lanes run side by side.
//   The next input can be taken once that result is in the output register
//   and not held by out_stall_i. All other results land in the output
//   register at the accept edge, one item per cycle while no result is held
//   and the divider is idle.
// Stall
//   One output register holds the result while out_stall_i is high; the
//   input stalls while the divider runs or while a held result is not taken.
// Reset
//   rst_ni clears the sequencer to idle and the tick rate to 60.
module pen_line_stroke_synthesizer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [plss_pkg::RATE_W-1:0]       cfg_tick_rate_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              action_i,
  input  logic [plss_pkg::COORD_BITS-1:0]   start_x_i,
  input  logic [plss_pkg::COORD_BITS-1:0]   start_y_i,
  input  logic [plss_pkg::COORD_BITS-1:0]   end_x_i,
  input  logic [plss_pkg::COORD_BITS-1:0]   end_y_i,
  input  logic                              selection_gesture_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [plss_pkg::KIND_W-1:0]       kind_o,
  output logic [plss_pkg::POS_W-1:0]        pos_x_o,
  output logic [plss_pkg::POS_W-1:0]        pos_y_o,
  output logic [plss_pkg::PRESS_W-1:0]      pressure_o,
  output logic [plss_pkg::PC_W-1:0]         point_count_o,
  output logic [plss_pkg::ET_W-1:0]         end_time_o,
  output logic                              last_o
);
  import plss_pkg::*;

  // Stroke phases
  localparam logic [2:0] PH_IDLE  = 3'd0;
  localparam logic [2:0] PH_DWELL = 3'd1;
  localparam logic [2:0] PH_LINE  = 3'd2;
  localparam logic [2:0] PH_UP    = 3'd3;
  localparam logic [2:0] PH_GAP   = 3'd4;
  localparam logic [2:0] PH_DOWN  = 3'd5;
  localparam logic [2:0] PH_LINE2 = 3'd6;

  // Gesture modes
  localparam logic [1:0] MODE_PLAIN  = 2'd0;
  localparam logic [1:0] MODE_SELECT = 2'd1;
  localparam logic [1:0] MODE_DTAP   = 2'd2;

  // Architectural state
  logic [RATE_W-1:0]     tick_rate_q, tick_rate_d;
  logic [2:0]            phase_q, phase_d;
  logic [IDX_W-1:0]      step_idx_q, step_idx_d;
  logic [STEP_W-1:0]     seg_steps_q, seg_steps_d;
  logic [COORD_BITS-1:0] org_x_q, org_x_d, org_y_q, org_y_d;
  logic [COORD_BITS-1:0] tgt_x_q, tgt_x_d, tgt_y_q, tgt_y_d;
  logic [1:0]            mode_q, mode_d;
  logic [GAP_W-1:0]      gap_left_q, gap_left_d;

  // Divider and pending header
  logic                  busy_q, busy_d;
  logic                  is_hdr_q, is_hdr_d;
  logic [DCNT_W-1:0]     dcnt_q, dcnt_d;
  logic [DVS_W-1:0]      dvs_q, dvs_d;
  logic [DVS_W-1:0]      rem_x_q, rem_x_d, rem_y_q, rem_y_d;
  logic [DIV_W-1:0]      quo_x_q, quo_x_d, quo_y_q, quo_y_d;
  logic [PC_W-1:0]       hdr_cnt_q, hdr_cnt_d;

  // Output register
  logic                  out_valid_q, out_valid_d;
  logic [KIND_W-1:0]     kind_q, kind_d;
  logic [POS_W-1:0]      pos_x_q, pos_x_d, pos_y_q, pos_y_d;
  logic [PRESS_W-1:0]    press_q, press_d;
  logic [PC_W-1:0]       pc_q, pc_d;
  logic [ET_W-1:0]       et_q, et_d;
  logic                  last_q, last_d;

  logic in_accept, out_free;

  // Start arithmetic
  logic [COORD_BITS-1:0] dx, dy, dmax;
  logic                  is_dtap, is_sel;
  logic [STEP_W-1:0]     steps_raw, steps_pick, steps;
  logic [RATE_W-1:0]     rate_eff;
  logic [GAP_PROD_W-1:0] gap_prod;
  logic [GAP_W-1:0]      gap;
  logic [CNT_W-1:0]      count_base, count;
  logic [DIV_W-1:0]      count60;
  logic [PC_W-1:0]       count_sat;

  // Interpolation products
  logic [COORD_BITS-1:0] dabs_x, dabs_y;
  logic [PROD_W-1:0]     prod_x, prod_y;
  logic                  line_fin, line_more;

  // Divider lanes
  logic [DVS_W:0]        trial_x, trial_y, diff_x, diff_y;
  logic                  ge_x, ge_y;

  // Finish values
  logic [ETF_W-1:0]      et_full, steps3;
  logic [ET_W-1:0]       et_sat;
  logic [COORD_BITS-1:0] vx, vy;
  logic [IDX_W-1:0]      idx_inc;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = busy_q || !out_free;
  assign in_accept   = in_valid_i && !in_stall_o;

  assign dx      = (start_x_i >= end_x_i) ? start_x_i - end_x_i : end_x_i - start_x_i;
  assign dy      = (start_y_i >= end_y_i) ? start_y_i - end_y_i : end_y_i - start_y_i;
  assign dmax    = (dx > dy) ? dx : dy;
  assign is_dtap = selection_gesture_i && (dx < COORD_BITS'(DTAP_LIMIT))
                   && (dy < COORD_BITS'(DTAP_LIMIT));
  assign is_sel  = selection_gesture_i && !is_dtap;

  assign steps_raw  = dmax[COORD_BITS-1:1];
  assign steps_pick = is_sel ? (steps_raw >> 2) : steps_raw;
  assign steps      = (steps_pick == '0) ? STEP_W'(STEPS_DEFAULT) : steps_pick;

  assign rate_eff = (tick_rate_q == '0) ? RATE_W'(1) : tick_rate_q;
  assign gap_prod = GAP_PROD_W'(rate_eff) * GAP_PROD_W'(GAP_RECIP);
  assign gap      = gap_prod[GAP_SHIFT +: GAP_W];

  assign count_base = CNT_W'(steps) + CNT_W'(1);
  always_comb begin
    if (is_dtap) begin
      count = (count_base << 1) + CNT_W'(gap) + CNT_W'(2);
    end else if (is_sel) begin
      count = count_base + CNT_W'(DWELL_SAMPLES);
    end else begin
      count = count_base;
    end
  end
  assign count60   = (DIV_W'(count) << 6) - (DIV_W'(count) << 2);
  assign count_sat = (count > CNT_W'(PC_MAX)) ? PC_W'(PC_MAX) : count[PC_W-1:0];

  assign dabs_x = (tgt_x_q >= org_x_q) ? tgt_x_q - org_x_q : org_x_q - tgt_x_q;
  assign dabs_y = (tgt_y_q >= org_y_q) ? tgt_y_q - org_y_q : org_y_q - tgt_y_q;
  assign prod_x = PROD_W'(step_idx_q) * PROD_W'(dabs_x);
  assign prod_y = PROD_W'(step_idx_q) * PROD_W'(dabs_y);

  assign line_fin  = step_idx_q >= IDX_W'(seg_steps_q);
  assign line_more = line_fin && (phase_q == PH_LINE) && (mode_q == MODE_DTAP);
  assign idx_inc   = step_idx_q + IDX_W'(1);

  // One restoring step per lane: shift in the next dividend bit, subtract if it fits
  assign trial_x = {rem_x_q, quo_x_q[DIV_W-1]};
  assign trial_y = {rem_y_q, quo_y_q[DIV_W-1]};
  assign ge_x    = trial_x >= {1'b0, dvs_q};
  assign ge_y    = trial_y >= {1'b0, dvs_q};
  assign diff_x  = trial_x - {1'b0, dvs_q};
  assign diff_y  = trial_y - {1'b0, dvs_q};

  // Header end time from the quotient on lane x
  assign steps3  = (ETF_W'(seg_steps_q) << 1) + ETF_W'(seg_steps_q);
  assign et_full = ETF_W'(ET_BASE) + ((mode_q == MODE_SELECT) ? steps3 : '0)
                   + ETF_W'(quo_x_q);
  always_comb begin
    if (et_full > ETF_W'(ET_MAX)) begin
      et_sat = ET_W'(ET_MAX);
    end else if (et_full == ETF_W'(ET_BASE)) begin
      et_sat = ET_W'(ET_BASE + 1);
    end else begin
      et_sat = et_full[ET_W-1:0];
    end
  end

  // Interpolated coordinate: origin plus or minus the truncated quotient
  assign vx = (tgt_x_q >= org_x_q) ? org_x_q + quo_x_q[COORD_BITS-1:0]
                                   : org_x_q - quo_x_q[COORD_BITS-1:0];
  assign vy = (tgt_y_q >= org_y_q) ? org_y_q + quo_y_q[COORD_BITS-1:0]
                                   : org_y_q - quo_y_q[COORD_BITS-1:0];

  always_comb begin
    tick_rate_d = tick_rate_q;
    phase_d     = phase_q;
    step_idx_d  = step_idx_q;
    seg_steps_d = seg_steps_q;
    org_x_d     = org_x_q;
    org_y_d     = org_y_q;
    tgt_x_d     = tgt_x_q;
    tgt_y_d     = tgt_y_q;
    mode_d      = mode_q;
    gap_left_d  = gap_left_q;
    busy_d      = busy_q;
    is_hdr_d    = is_hdr_q;
    dcnt_d      = dcnt_q;
    dvs_d       = dvs_q;
    rem_x_d     = rem_x_q;
    rem_y_d     = rem_y_q;
    quo_x_d     = quo_x_q;
    quo_y_d     = quo_y_q;
    hdr_cnt_d   = hdr_cnt_q;
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    pos_x_d     = pos_x_q;
    pos_y_d     = pos_y_q;
    press_d     = press_q;
    pc_d        = pc_q;
    et_d        = et_q;
    last_d      = last_q;

    if (cfg_valid_i) begin
      tick_rate_d = cfg_tick_rate_i;
    end

    // Drop the held result once it is taken
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    if (busy_q) begin
      if (dcnt_q != '0) begin
        // Advance both lanes by one quotient bit
        rem_x_d = ge_x ? diff_x[DVS_W-1:0] : trial_x[DVS_W-1:0];
        rem_y_d = ge_y ? diff_y[DVS_W-1:0] : trial_y[DVS_W-1:0];
        quo_x_d = {quo_x_q[DIV_W-2:0], ge_x};
        quo_y_d = {quo_y_q[DIV_W-2:0], ge_y};
        dcnt_d  = dcnt_q - DCNT_W'(1);
      end else if (out_free) begin
        busy_d      = 1'b0;
        out_valid_d = 1'b1;
        last_d      = 1'b0;
        if (is_hdr_q) begin
          kind_d  = KIND_HEADER;
          pos_x_d = '0;
          pos_y_d = '0;
          press_d = '0;
          pc_d    = hdr_cnt_q;
          et_d    = et_sat;
        end else begin
          kind_d  = KIND_PEN;
          pos_x_d = {vx, 3'b000};
          pos_y_d = {vy, 3'b000};
          press_d = PEN_PRESSURE;
          pc_d    = '0;
          et_d    = '0;
        end
      end
    end

    if (in_accept) begin
      if (!action_i) begin
        // Start: latch the stroke and send the end-time division to lane x
        org_x_d     = start_x_i;
        org_y_d     = start_y_i;
        tgt_x_d     = end_x_i;
        tgt_y_d     = end_y_i;
        mode_d      = is_dtap ? MODE_DTAP : (is_sel ? MODE_SELECT : MODE_PLAIN);
        seg_steps_d = steps;
        gap_left_d  = is_dtap ? gap : '0;
        step_idx_d  = '0;
        phase_d     = is_sel ? PH_DWELL : PH_LINE;
        hdr_cnt_d   = count_sat;
        busy_d      = 1'b1;
        is_hdr_d    = 1'b1;
        dcnt_d      = DCNT_W'(DIV_W);
        dvs_d       = DVS_W'(rate_eff);
        rem_x_d     = '0;
        rem_y_d     = '0;
        quo_x_d     = is_sel ? DIV_W'(ET_SELECT_NUM) : count60;
        quo_y_d     = '0;
        out_valid_d = 1'b0;
      end else begin
        // Pull: default to a blank result, then fill in per phase
        out_valid_d = 1'b1;
        kind_d      = KIND_IDLE;
        pos_x_d     = '0;
        pos_y_d     = '0;
        press_d     = '0;
        pc_d        = '0;
        et_d        = '0;
        last_d      = 1'b0;
        case (phase_q)
          PH_DWELL: begin
            kind_d  = KIND_PEN;
            pos_x_d = {org_x_q, 3'b000};
            pos_y_d = {org_y_q, 3'b000};
            press_d = PEN_PRESSURE;
            if (idx_inc >= IDX_W'(DWELL_SAMPLES)) begin
              step_idx_d = '0;
              phase_d    = PH_LINE;
            end else begin
              step_idx_d = idx_inc;
            end
          end
          PH_LINE, PH_LINE2: begin
            if (line_fin) begin
              kind_d  = KIND_PEN;
              pos_x_d = {tgt_x_q, 3'b000};
              pos_y_d = {tgt_y_q, 3'b000};
              press_d = PEN_PRESSURE;
              last_d  = !line_more;
              phase_d = line_more ? PH_UP : PH_IDLE;
            end else begin
              // Mid-line sample: divide |d| * i by the step count on both lanes
              out_valid_d = 1'b0;
              busy_d      = 1'b1;
              is_hdr_d    = 1'b0;
              dcnt_d      = DCNT_W'(DIV_W);
              dvs_d       = DVS_W'(seg_steps_q);
              rem_x_d     = '0;
              rem_y_d     = '0;
              quo_x_d     = DIV_W'(prod_x);
              quo_y_d     = DIV_W'(prod_y);
              step_idx_d  = idx_inc;
            end
          end
          PH_UP: begin
            kind_d  = KIND_UP;
            phase_d = (gap_left_q != '0) ? PH_GAP : PH_DOWN;
          end
          PH_GAP: begin
            kind_d = KIND_GAP;
            if (gap_left_q <= GAP_W'(1)) begin
              gap_left_d = '0;
              phase_d    = PH_DOWN;
            end else begin
              gap_left_d = gap_left_q - GAP_W'(1);
            end
          end
          PH_DOWN: begin
            kind_d     = KIND_DOWN;
            step_idx_d = '0;
            phase_d    = PH_LINE2;
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_rate_q <= TICK_RATE_RESET;
      phase_q     <= PH_IDLE;
      step_idx_q  <= '0;
      seg_steps_q <= '0;
      org_x_q     <= '0;
      org_y_q     <= '0;
      tgt_x_q     <= '0;
      tgt_y_q     <= '0;
      mode_q      <= MODE_PLAIN;
      gap_left_q  <= '0;
      busy_q      <= 1'b0;
      is_hdr_q    <= 1'b0;
      dcnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      tick_rate_q <= tick_rate_d;
      phase_q     <= phase_d;
      step_idx_q  <= step_idx_d;
      seg_steps_q <= seg_steps_d;
      org_x_q     <= org_x_d;
      org_y_q     <= org_y_d;
      tgt_x_q     <= tgt_x_d;
      tgt_y_q     <= tgt_y_d;
      mode_q      <= mode_d;
      gap_left_q  <= gap_left_d;
      busy_q      <= busy_d;
      is_hdr_q    <= is_hdr_d;
      dcnt_q      <= dcnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: no reset
  always_ff @(posedge clk_i) begin
    dvs_q     <= dvs_d;
    rem_x_q   <= rem_x_d;
    rem_y_q   <= rem_y_d;
    quo_x_q   <= quo_x_d;
    quo_y_q   <= quo_y_d;
    hdr_cnt_q <= hdr_cnt_d;
    kind_q    <= kind_d;
    pos_x_q   <= pos_x_d;
    pos_y_q   <= pos_y_d;
    press_q   <= press_d;
    pc_q      <= pc_d;
    et_q      <= et_d;
    last_q    <= last_d;
  end

  assign out_valid_o   = out_valid_q;
  assign kind_o        = kind_q;
  assign pos_x_o       = pos_x_q;
  assign pos_y_o       = pos_y_q;
  assign pressure_o    = press_q;
  assign point_count_o = pc_q;
  assign end_time_o    = et_q;
  assign last_o        = last_q;

endmodule

FILE: rtl/plss_checker.sv
// Port-level checker for the pen line stroke synthesizer, bound to the top level.
// Depends on plss_pkg.
module plss_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              cfg_valid_i,
  input logic                              cfg_ready_o,
  input logic [plss_pkg::RATE_W-1:0]       cfg_tick_rate_i,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              action_i,
  input logic [plss_pkg::COORD_BITS-1:0]   start_x_i,
  input logic [plss_pkg::COORD_BITS-1:0]   start_y_i,
  input logic [plss_pkg::COORD_BITS-1:0]   end_x_i,
  input logic [plss_pkg::COORD_BITS-1:0]   end_y_i,
  input logic                              selection_gesture_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [plss_pkg::KIND_W-1:0]       kind_o,
  input logic [plss_pkg::POS_W-1:0]        pos_x_o,
  input logic [plss_pkg::POS_W-1:0]        pos_y_o,
  input logic [plss_pkg::PRESS_W-1:0]      pressure_o,
  input logic [plss_pkg::PC_W-1:0]         point_count_o,
  input logic [plss_pkg::ET_W-1:0]         end_time_o,
  input logic                              last_o
);
  import plss_pkg::*;

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(kind_o) && $stable(pos_x_o)
      && $stable(pos_y_o) && $stable(last_o) && $stable(end_time_o))
    else $error("stalled result changed");

  a_pen_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_PEN |->
      pressure_o == PEN_PRESSURE && point_count_o == '0 && end_time_o == '0)
    else $error("pen sample carries header fields or wrong pressure");

  a_nonpen_blank: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o != KIND_PEN |->
      pos_x_o == '0 && pos_y_o == '0 && pressure_o == '0 && !last_o)
    else $error("non-pen result carries position, pressure or last");

  a_header_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && kind_o == KIND_HEADER |->
      end_time_o > ET_W'(ET_BASE) && point_count_o >= PC_W'(2))
    else $error("header end time or point count out of range");

endmodule

bind pen_line_stroke_synthesizer plss_checker u_plss_checker (.*);
